FILE: rtl/bfhp_pkg.sv
package bfhp_pkg;

   localparam int unsigned PREAMBLE_LEN   = 13;
   localparam int unsigned PRE_IDX_W      = 4;
   localparam int unsigned SECT_LEN_W     = 32;

   localparam logic [7:0]  SEARCH_LIMIT_RST  = 8'd100;
   localparam logic [6:0]  CONTENT_LIMIT_RST = 7'd40;
   localparam logic [6:0]  MAX_CONTENT       = 7'd64;
   localparam logic [7:0]  MAX_SHORT_BYTE    = 8'd64;
   localparam logic [31:0] MAX_SHORT_LEN     = 32'd255;

   localparam logic [7:0]  CHAR_A     = 8'h61;  // 'a'
   localparam logic [7:0]  CHAR_E     = 8'h65;  // 'e'
   localparam logic [7:0]  CHAR_SLASH = 8'h2f;  // '/'
   localparam logic [7:0]  CHAR_DASH  = 8'h2d;  // '-'
   localparam logic [7:0]  CHAR_SPACE = 8'h20;  // ' '
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;  // '0'

   localparam logic [2:0]  LETTER_E   = 3'd4;

   // section ids
   localparam logic [1:0]  SECT_C = 2'd2;
   localparam logic [1:0]  SECT_D = 2'd3;

   // result status codes
   localparam logic [2:0]  ST_CONTENT      = 3'd0;
   localparam logic [2:0]  ST_ALL_FOUND    = 3'd1;
   localparam logic [2:0]  ST_BAD_PREAMBLE = 3'd2;
   localparam logic [2:0]  ST_FORMAT       = 3'd3;
   localparam logic [2:0]  ST_BUDGET       = 3'd4;

   // config register indexes
   localparam logic        REG_SEARCH_LIMIT  = 1'b0;
   localparam logic        REG_CONTENT_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      PH_DONE     = 3'd0,
      PH_PREAMBLE = 3'd1,
      PH_NAME     = 3'd2,
      PH_LENGTH   = 3'd3,
      PH_CONTENT  = 3'd4,
      PH_SKIP     = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] section_id;
      logic       section_last;
      logic [2:0] status;
   } result_type;

   function automatic logic [7:0] preamble_byte(input logic [PRE_IDX_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h00;
         4'd1:    b = 8'h09;
         4'd2:    b = 8'h0f;
         4'd3:    b = 8'hf0;
         4'd4:    b = 8'h0f;
         4'd5:    b = 8'hf0;
         4'd6:    b = 8'h0f;
         4'd7:    b = 8'hf0;
         4'd8:    b = 8'h0f;
         4'd9:    b = 8'hf0;
         4'd10:   b = 8'h00;
         4'd11:   b = 8'h00;
         4'd12:   b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/bfhp_if.sv
interface bfhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;

   modport source (output valid, output data_byte, output start_of_file, input ready);
   modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface bfhp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] section_id;
   logic       section_last;
   logic [2:0] status;

   modport source (output valid, output out_byte, output section_id,
                   output section_last, output status, input ready);
   modport sink   (input valid, input out_byte, input section_id,
                   input section_last, input status, output ready);
endinterface

interface bfhp_csr_if;
   logic       valid;
   logic       ready;
   logic       addr;
   logic [7:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

FILE: rtl/bfhp_core.sv
module bfhp_core
   import bfhp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       start_of_file,
   input  logic [7:0] search_limit,
   input  logic [6:0] content_limit,
   output logic       res_hit,
   output result_type res
);

   phase_type             phase_ff, phase_in, cur_phase;
   logic [PRE_IDX_W-1:0]  pre_idx_ff, pre_idx_in, cur_pre_idx;
   logic [1:0]            wanted_ff, wanted_in, cur_wanted;
   logic [2:0]            letter_ff, letter_in, cur_letter;
   logic [2:0]            len_left_ff, len_left_in, cur_len_left, len_left_dec;
   logic [SECT_LEN_W-1:0] sect_len_ff, sect_len_in, cur_sect_len, sect_len_dec, new_len;
   logic [7:0]            search_ff, search_in, cur_search, search_inc;
   logic [6:0]            emitted_ff, emitted_in, cur_emitted;
   logic [6:0]            eff_limit;
   logic [7:0]            sub_byte;
   logic                  is_short;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_DONE;
         pre_idx_ff  <= '0;
         wanted_ff   <= '0;
         letter_ff   <= '0;
         len_left_ff <= '0;
         sect_len_ff <= '0;
         search_ff   <= '0;
         emitted_ff  <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         pre_idx_ff  <= pre_idx_in;
         wanted_ff   <= wanted_in;
         letter_ff   <= letter_in;
         len_left_ff <= len_left_in;
         sect_len_ff <= sect_len_in;
         search_ff   <= search_in;
         emitted_ff  <= emitted_in;
      end
   end

   // start of file wipes the parse state before the byte is looked at
   always_comb begin
      if (start_of_file) begin
         cur_phase    = PH_PREAMBLE;
         cur_pre_idx  = '0;
         cur_wanted   = '0;
         cur_letter   = '0;
         cur_len_left = '0;
         cur_sect_len = '0;
         cur_search   = '0;
         cur_emitted  = '0;
      end else begin
         cur_phase    = phase_ff;
         cur_pre_idx  = pre_idx_ff;
         cur_wanted   = wanted_ff;
         cur_letter   = letter_ff;
         cur_len_left = len_left_ff;
         cur_sect_len = sect_len_ff;
         cur_search   = search_ff;
         cur_emitted  = emitted_ff;
      end
   end

   assign search_inc   = (cur_search == 8'hff) ? cur_search : cur_search + 8'd1;
   assign sect_len_dec = (cur_sect_len != '0) ? cur_sect_len - 32'd1 : cur_sect_len;
   assign len_left_dec = (cur_len_left != '0) ? cur_len_left - 3'd1 : cur_len_left;
   assign new_len      = {cur_sect_len[23:0], data_byte};
   assign is_short     = (cur_letter != LETTER_E);
   assign eff_limit    = (content_limit > MAX_CONTENT) ? MAX_CONTENT : content_limit;

   always_comb begin
      sub_byte = data_byte;
      if (cur_wanted == SECT_C && data_byte == CHAR_SLASH) begin
         sub_byte = CHAR_DASH;
      end
      if ((cur_wanted == SECT_C || cur_wanted == SECT_D) && data_byte == CHAR_SPACE) begin
         sub_byte = CHAR_ZERO;
      end
   end

   always_comb begin
      phase_in    = cur_phase;
      pre_idx_in  = cur_pre_idx;
      wanted_in   = cur_wanted;
      letter_in   = cur_letter;
      len_left_in = cur_len_left;
      sect_len_in = cur_sect_len;
      search_in   = cur_search;
      emitted_in  = cur_emitted;
      res_hit     = 1'b0;
      res         = '{out_byte: 8'h00, section_id: cur_wanted, section_last: 1'b0,
                      status: ST_CONTENT};

      unique case (cur_phase)
         PH_DONE: begin
         end
         PH_PREAMBLE: begin
            if (cur_pre_idx >= PRE_IDX_W'(PREAMBLE_LEN) ||
                data_byte != preamble_byte(cur_pre_idx)) begin
               phase_in   = PH_DONE;
               res_hit    = 1'b1;
               res.status = ST_BAD_PREAMBLE;
            end else begin
               pre_idx_in = cur_pre_idx + 4'd1;
               if (cur_pre_idx == PRE_IDX_W'(PREAMBLE_LEN - 1)) begin
                  search_in = '0;
                  phase_in  = PH_NAME;
               end
            end
         end
         PH_NAME: begin
            if (cur_search >= search_limit) begin
               phase_in   = PH_DONE;
               res_hit    = 1'b1;
               res.status = ST_BUDGET;
            end else begin
               search_in = search_inc;
               if (data_byte < CHAR_A || data_byte > CHAR_E) begin
                  phase_in   = PH_DONE;
                  res_hit    = 1'b1;
                  res.status = ST_FORMAT;
               end else begin
                  letter_in   = 3'(data_byte - CHAR_A);
                  len_left_in = (3'(data_byte - CHAR_A) == LETTER_E) ? 3'd4 : 3'd2;
                  sect_len_in = '0;
                  phase_in    = PH_LENGTH;
               end
            end
         end
         PH_LENGTH: begin
            search_in = search_inc;
            if (is_short && data_byte > MAX_SHORT_BYTE) begin
               phase_in   = PH_DONE;
               res_hit    = 1'b1;
               res.status = ST_FORMAT;
            end else begin
               sect_len_in = new_len;
               len_left_in = len_left_dec;
               if (len_left_dec == '0) begin
                  if (is_short && new_len > MAX_SHORT_LEN) begin
                     phase_in   = PH_DONE;
                     res_hit    = 1'b1;
                     res.status = ST_FORMAT;
                  end else if (cur_letter == {1'b0, cur_wanted}) begin
                     emitted_in = '0;
                     if (cur_wanted == SECT_D) begin
                        phase_in   = (new_len != '0) ? PH_CONTENT : PH_DONE;
                        res_hit    = 1'b1;
                        res.status = ST_ALL_FOUND;
                     end else if (new_len == '0) begin
                        wanted_in = cur_wanted + 2'd1;
                        search_in = '0;
                        phase_in  = PH_NAME;
                     end else begin
                        phase_in = PH_CONTENT;
                     end
                  end else begin
                     phase_in = (new_len != '0) ? PH_SKIP : PH_NAME;
                  end
               end
            end
         end
         PH_SKIP: begin
            if (cur_search >= search_limit) begin
               phase_in   = PH_DONE;
               res_hit    = 1'b1;
               res.status = ST_BUDGET;
            end else begin
               search_in   = search_inc;
               sect_len_in = sect_len_dec;
               if (sect_len_dec == '0) begin
                  phase_in = PH_NAME;
               end
            end
         end
         PH_CONTENT: begin
            sect_len_in = sect_len_dec;
            if (cur_emitted < eff_limit) begin
               emitted_in       = cur_emitted + 7'd1;
               res_hit          = 1'b1;
               res.out_byte     = sub_byte;
               res.section_last = (sect_len_dec == '0) || (cur_emitted + 7'd1 == eff_limit);
            end
            if (sect_len_dec == '0) begin
               if (cur_wanted == SECT_D) begin
                  phase_in = PH_DONE;
               end else begin
                  wanted_in = cur_wanted + 2'd1;
                  search_in = '0;
                  phase_in  = PH_NAME;
               end
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

endmodule

FILE: rtl/bit_file_header_parser.sv
// Channel  Dir  Payload                                         Accept
// req_ch   in   data_byte[7:0], start_of_file                   valid & ready
// rsp_ch   out  out_byte[7:0], section_id[1:0], section_last,   valid & ready
//               status[2:0]
// csr_ch   in   addr (0 search_limit, 1 content_limit), wdata   valid & ready
//
// One byte per cycle unless stalled. Each byte is parsed in the cycle it is
// taken; its result (zero or one item) sits in the output register on the next
// cycle. req_ch.ready drops only while a result is held and rsp_ch is
// stalled, so a new byte enters in the same cycle the held result leaves.
// reset (synchronous) sets search_limit 100, content_limit 40 and an idle
// parse that waits for start_of_file. csr_ch is always ready.
module bit_file_header_parser
   import bfhp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bfhp_req_if.sink   req_ch,
   bfhp_rsp_if.source rsp_ch,
   bfhp_csr_if.sink   csr_ch
);

   logic [7:0] search_limit_ff;
   logic [6:0] content_limit_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type res;
   logic       res_hit;
   logic       step;

   // config registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         search_limit_ff  <= SEARCH_LIMIT_RST;
         content_limit_ff <= CONTENT_LIMIT_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.addr)
            REG_SEARCH_LIMIT:  search_limit_ff  <= csr_ch.wdata;
            REG_CONTENT_LIMIT: content_limit_ff <= csr_ch.wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // a byte is taken whenever the output register is free or draining
   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;
   assign step         = req_ch.valid && req_ch.ready;

   bfhp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .data_byte     (req_ch.data_byte),
      .start_of_file (req_ch.start_of_file),
      .search_limit  (search_limit_ff),
      .content_limit (content_limit_ff),
      .res_hit       (res_hit),
      .res           (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && res_hit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_hit) begin
         out_ff <= res;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.out_byte     = out_ff.out_byte;
   assign rsp_ch.section_id   = out_ff.section_id;
   assign rsp_ch.section_last = out_ff.section_last;
   assign rsp_ch.status       = out_ff.status;

endmodule
